### sv/gcce_pkg.sv
// Package for the grid cell cover enumerator: types, register indexes,
// reset values and the command/status structs shared by controller and datapath.
// No dependencies.
`default_nettype none

package gcce_pkg;

    // Configuration port geometry
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 15;

    // Register indexes
    localparam logic [CFG_AW-1:0] REG_CELL_W   = 3'd0;
    localparam logic [CFG_AW-1:0] REG_CELL_H   = 3'd1;
    localparam logic [CFG_AW-1:0] REG_GRID_COL = 3'd2;
    localparam logic [CFG_AW-1:0] REG_GRID_ROW = 3'd3;
    localparam logic [CFG_AW-1:0] REG_SCR_W    = 3'd4;
    localparam logic [CFG_AW-1:0] REG_SCR_H    = 3'd5;

    // Register reset values
    localparam logic [11:0] RST_CELL_W   = 12'd160;
    localparam logic [11:0] RST_CELL_H   = 12'd120;
    localparam logic [3:0]  RST_GRID_COL = 4'd4;
    localparam logic [3:0]  RST_GRID_ROW = 4'd4;
    localparam logic [14:0] RST_SCR_W    = 15'd640;
    localparam logic [14:0] RST_SCR_H    = 15'd480;

    // Grid limits
    localparam logic [3:0] MAX_COLUMNS = 4'd8;
    localparam logic [3:0] MAX_ROWS    = 4'd8;

    // Beat widths
    localparam int S_DW = 64;
    localparam int M_DW = 16;

    // Divider selection
    localparam logic DIV_SEL_X = 1'b0;
    localparam logic DIV_SEL_Y = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIVX,
        ST_INITY,
        ST_DIVY,
        ST_EMIT,
        ST_EMPTY
    } state_t;

    typedef struct packed {
        logic load_in;
        logic div_init;
        logic div_sel;
        logic div_step;
        logic div_store;
        logic emit_cell;
        logic emit_empty;
    } cmd_t;

    typedef struct packed {
        logic off_screen;
        logic div_last;
        logic last_cell;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

### sv/gcce_ctrl.sv
// Controller for the grid cell cover enumerator: sequences clipping, the
// two division passes and cell emission. Depends on gcce_pkg.
`default_nettype none

module gcce_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  gcce_pkg::sts_t     sts,
    output gcce_pkg::cmd_t     cmd
);

    gcce_pkg::state_t state_reg;
    gcce_pkg::state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gcce_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            gcce_pkg::ST_IDLE: begin
                if (s_tvalid) state_next = gcce_pkg::ST_CHECK;
            end
            gcce_pkg::ST_CHECK: begin
                state_next = sts.off_screen ? gcce_pkg::ST_EMPTY : gcce_pkg::ST_DIVX;
            end
            gcce_pkg::ST_DIVX: begin
                if (sts.div_last) state_next = gcce_pkg::ST_INITY;
            end
            gcce_pkg::ST_INITY: begin
                state_next = gcce_pkg::ST_DIVY;
            end
            gcce_pkg::ST_DIVY: begin
                if (sts.div_last) state_next = gcce_pkg::ST_EMIT;
            end
            gcce_pkg::ST_EMIT: begin
                if (sts.out_free && sts.last_cell) state_next = gcce_pkg::ST_IDLE;
            end
            gcce_pkg::ST_EMPTY: begin
                if (sts.out_free) state_next = gcce_pkg::ST_IDLE;
            end
            default: state_next = gcce_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        s_tready = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            gcce_pkg::ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
            end
            gcce_pkg::ST_CHECK: begin
                cmd.div_init = !sts.off_screen;
                cmd.div_sel  = gcce_pkg::DIV_SEL_X;
            end
            gcce_pkg::ST_DIVX: begin
                cmd.div_step  = 1'b1;
                cmd.div_sel   = gcce_pkg::DIV_SEL_X;
                cmd.div_store = sts.div_last;
            end
            gcce_pkg::ST_INITY: begin
                cmd.div_init = 1'b1;
                cmd.div_sel  = gcce_pkg::DIV_SEL_Y;
            end
            gcce_pkg::ST_DIVY: begin
                cmd.div_step  = 1'b1;
                cmd.div_sel   = gcce_pkg::DIV_SEL_Y;
                cmd.div_store = sts.div_last;
            end
            gcce_pkg::ST_EMIT: begin
                cmd.emit_cell = sts.out_free;
            end
            gcce_pkg::ST_EMPTY: begin
                cmd.emit_empty = sts.out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

### sv/gcce_dp.sv
// Datapath for the grid cell cover enumerator: configuration registers,
// screen clipping, two-lane restoring divider, cell cursor and output register.
// Depends on gcce_pkg.
`default_nettype none

module gcce_dp (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_wr_en,
    input  wire logic [gcce_pkg::CFG_AW-1:0]  cfg_addr,
    input  wire logic [gcce_pkg::CFG_DW-1:0]  cfg_wr_data,
    input  wire logic [gcce_pkg::S_DW-1:0]    s_tdata,
    input  gcce_pkg::cmd_t                    cmd,
    output gcce_pkg::sts_t                    sts,
    input  wire logic                         m_tready,
    output logic                              m_tvalid,
    output logic [gcce_pkg::M_DW-1:0]         m_tdata,
    output logic                              m_tuser,
    output logic                              m_tlast
);

    // Configuration registers
    logic [11:0] cw_reg, ch_reg;
    logic [3:0]  cols_reg, rows_reg;
    logic [14:0] sw_reg, sh_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cw_reg   <= gcce_pkg::RST_CELL_W;
            ch_reg   <= gcce_pkg::RST_CELL_H;
            cols_reg <= gcce_pkg::RST_GRID_COL;
            rows_reg <= gcce_pkg::RST_GRID_ROW;
            sw_reg   <= gcce_pkg::RST_SCR_W;
            sh_reg   <= gcce_pkg::RST_SCR_H;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                gcce_pkg::REG_CELL_W:   cw_reg   <= cfg_wr_data[11:0];
                gcce_pkg::REG_CELL_H:   ch_reg   <= cfg_wr_data[11:0];
                gcce_pkg::REG_GRID_COL: cols_reg <= cfg_wr_data[3:0];
                gcce_pkg::REG_GRID_ROW: rows_reg <= cfg_wr_data[3:0];
                gcce_pkg::REG_SCR_W:    sw_reg   <= cfg_wr_data;
                gcce_pkg::REG_SCR_H:    sh_reg   <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Effective configuration: zero sizes count as one, grid saturated
    logic [11:0] cw_eff, ch_eff;
    logic [3:0]  cols_eff, rows_eff, cols_m1, rows_m1;
    logic [14:0] sw_eff, sh_eff, sw_m1, sh_m1;
    logic [2:0]  col_max, row_max;

    always_comb begin
        cw_eff = (cw_reg == 12'd0) ? 12'd1 : cw_reg;
        ch_eff = (ch_reg == 12'd0) ? 12'd1 : ch_reg;
        sw_eff = (sw_reg == 15'd0) ? 15'd1 : sw_reg;
        sh_eff = (sh_reg == 15'd0) ? 15'd1 : sh_reg;
        sw_m1  = sw_eff - 15'd1;
        sh_m1  = sh_eff - 15'd1;
        priority if (cols_reg == 4'd0)                   cols_eff = 4'd1;
        else if (cols_reg > gcce_pkg::MAX_COLUMNS)       cols_eff = gcce_pkg::MAX_COLUMNS;
        else                                             cols_eff = cols_reg;
        priority if (rows_reg == 4'd0)                   rows_eff = 4'd1;
        else if (rows_reg > gcce_pkg::MAX_ROWS)          rows_eff = gcce_pkg::MAX_ROWS;
        else                                             rows_eff = rows_reg;
        cols_m1 = cols_eff - 4'd1;
        rows_m1 = rows_eff - 4'd1;
        col_max = cols_m1[2:0];
        row_max = rows_m1[2:0];
    end

    // Unpack the input beat and clip against the screen
    logic [15:0] in_x, in_y;
    logic [14:0] in_w, in_h;
    logic [16:0] x_ext, y_ext, xr_ext, yb_ext;
    logic        off_x, off_y;
    logic [14:0] l_clip, t_clip, r_clip, b_clip;

    always_comb begin
        in_x   = s_tdata[15:0];
        in_y   = s_tdata[31:16];
        in_w   = s_tdata[46:32];
        in_h   = s_tdata[61:47];
        x_ext  = {in_x[15], in_x};
        y_ext  = {in_y[15], in_y};
        xr_ext = x_ext + {2'b00, in_w};
        yb_ext = y_ext + {2'b00, in_h};
        off_x  = ($signed(x_ext) >= $signed({2'b00, sw_eff})) || xr_ext[16];
        off_y  = ($signed(y_ext) >= $signed({2'b00, sh_eff})) || yb_ext[16];
        l_clip = in_x[15] ? 15'd0 : in_x[14:0];
        t_clip = in_y[15] ? 15'd0 : in_y[14:0];
        r_clip = ($signed(xr_ext) > $signed({2'b00, sw_m1})) ? sw_m1 : xr_ext[14:0];
        b_clip = ($signed(yb_ext) > $signed({2'b00, sh_m1})) ? sh_m1 : yb_ext[14:0];
    end

    // Hold the clipped rectangle
    logic        off_reg;
    logic [14:0] l_reg, r_reg, t_reg, b_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            off_reg <= off_x || off_y;
            l_reg   <= l_clip;
            r_reg   <= r_clip;
            t_reg   <= t_clip;
            b_reg   <= b_clip;
        end
    end

    // Two-lane restoring divider: one overflow check, then three quotient bits
    logic [14:0] rem_a_reg, rem_b_reg, rem_a_next, rem_b_next;
    logic [2:0]  q_a_reg, q_b_reg, q_a_next, q_b_next;
    logic        sat_a_reg, sat_b_reg, sat_a_next, sat_b_next;
    logic [1:0]  step_reg;
    logic [11:0] div_d;
    logic [2:0]  q_max, q_bit, q_a_fin, q_b_fin;
    logic [14:0] div_sh;
    logic        ge_a, ge_b;

    always_comb begin
        div_d = (cmd.div_sel == gcce_pkg::DIV_SEL_Y) ? ch_eff : cw_eff;
        q_max = (cmd.div_sel == gcce_pkg::DIV_SEL_Y) ? row_max : col_max;
        unique case (step_reg)
            2'd0: begin div_sh = {div_d, 3'b000};        q_bit = 3'b000; end
            2'd1: begin div_sh = {1'b0, div_d, 2'b00};   q_bit = 3'b100; end
            2'd2: begin div_sh = {2'b00, div_d, 1'b0};   q_bit = 3'b010; end
            2'd3: begin div_sh = {3'b000, div_d};        q_bit = 3'b001; end
            default: begin div_sh = {3'b000, div_d};     q_bit = 3'b001; end
        endcase
        ge_a       = rem_a_reg >= div_sh;
        ge_b       = rem_b_reg >= div_sh;
        rem_a_next = rem_a_reg;
        rem_b_next = rem_b_reg;
        q_a_next   = q_a_reg;
        q_b_next   = q_b_reg;
        sat_a_next = sat_a_reg;
        sat_b_next = sat_b_reg;
        if (step_reg == 2'd0) begin
            sat_a_next = sat_a_reg || ge_a;
            sat_b_next = sat_b_reg || ge_b;
        end else begin
            if (!sat_a_reg && ge_a) begin
                rem_a_next = rem_a_reg - div_sh;
                q_a_next   = q_a_reg | q_bit;
            end
            if (!sat_b_reg && ge_b) begin
                rem_b_next = rem_b_reg - div_sh;
                q_b_next   = q_b_reg | q_bit;
            end
        end
        // Clamp to the last grid column or row
        q_a_fin = (sat_a_next || (q_a_next > q_max)) ? q_max : q_a_next;
        q_b_fin = (sat_b_next || (q_b_next > q_max)) ? q_max : q_b_next;
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_init) begin
            rem_a_reg <= (cmd.div_sel == gcce_pkg::DIV_SEL_Y) ? t_reg : l_reg;
            rem_b_reg <= (cmd.div_sel == gcce_pkg::DIV_SEL_Y) ? b_reg : r_reg;
            q_a_reg   <= 3'd0;
            q_b_reg   <= 3'd0;
            sat_a_reg <= 1'b0;
            sat_b_reg <= 1'b0;
            step_reg  <= 2'd0;
        end else if (cmd.div_step) begin
            rem_a_reg <= rem_a_next;
            rem_b_reg <= rem_b_next;
            q_a_reg   <= q_a_next;
            q_b_reg   <= q_b_next;
            sat_a_reg <= sat_a_next;
            sat_b_reg <= sat_b_next;
            step_reg  <= step_reg + 2'd1;
        end
    end

    // Cell span and cursor
    logic [2:0] c0_reg, c1_reg, r1_reg;
    logic [2:0] cur_col_reg, cur_row_reg;
    logic       last_cell;

    assign last_cell = (cur_row_reg == r1_reg) && (cur_col_reg == c1_reg);

    always_ff @(posedge aclk) begin
        if (cmd.div_store) begin
            if (cmd.div_sel == gcce_pkg::DIV_SEL_Y) begin
                r1_reg      <= q_b_fin;
                cur_row_reg <= q_a_fin;
                cur_col_reg <= c0_reg;
            end else begin
                c0_reg <= q_a_fin;
                c1_reg <= q_b_fin;
            end
        end else if (cmd.emit_cell) begin
            // Advance left to right, then down a row
            if (cur_col_reg == c1_reg) begin
                cur_col_reg <= c0_reg;
                cur_row_reg <= cur_row_reg + 3'd1;
            end else begin
                cur_col_reg <= cur_col_reg + 3'd1;
            end
        end
    end

    // Row-major index of the current cell
    logic [6:0] row_prod;
    logic [5:0] cell_idx;

    always_comb begin
        row_prod = {4'b0000, cur_row_reg} * {3'b000, cols_eff};
        cell_idx = row_prod[5:0] + {3'b000, cur_col_reg};
    end

    // Output register
    logic                      m_valid_reg;
    logic [gcce_pkg::M_DW-1:0] m_data_reg;
    logic                      m_user_reg, m_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit_cell || cmd.emit_empty) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_cell) begin
            m_data_reg <= {4'b0000, cur_row_reg, cur_col_reg, cell_idx};
            m_user_reg <= 1'b0;
            m_last_reg <= last_cell;
        end else if (cmd.emit_empty) begin
            m_data_reg <= '0;
            m_user_reg <= 1'b1;
            m_last_reg <= 1'b1;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    // Status to the controller
    always_comb begin
        sts.off_screen = off_reg;
        sts.div_last   = (step_reg == 2'd3);
        sts.last_cell  = last_cell;
        sts.out_free   = !m_valid_reg || m_tready;
    end

endmodule

`default_nettype wire

### sv/grid_cell_cover_enumerator_top.sv
// Grid cell cover enumerator: a rectangle beat in, one beat out per covered cell;
// an off-screen rectangle gives a single empty beat with m_tuser and m_tlast set.
// Steps: clip into registers, column division, row setup, row division, emit.
// A new rectangle is taken only after the previous one is done; the shared two-lane
// divider takes 4 steps per axis, then one cell per cycle unless m_tready stalls.
// Reset (aresetn, synchronous, active low) restores register defaults, idles the FSM.
`default_nettype none

module grid_cell_cover_enumerator_top (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // Configuration write port
    input  wire logic                         cfg_wr_en,
    input  wire logic [gcce_pkg::CFG_AW-1:0]  cfg_addr,
    input  wire logic [gcce_pkg::CFG_DW-1:0]  cfg_wr_data,
    // Rectangle input
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    // rect_left[15:0], rect_top[31:16], rect_width[46:32], rect_height[61:47], zero pad
    input  wire logic [gcce_pkg::S_DW-1:0]    s_tdata,
    // Cell output
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // cell_index[5:0], cell_column[8:6], cell_row[11:9], zero pad
    output logic [gcce_pkg::M_DW-1:0]         m_tdata,
    // empty_res[0]
    output logic                              m_tuser,
    output logic                              m_tlast
);

    gcce_pkg::cmd_t cmd;
    gcce_pkg::sts_t sts;

    gcce_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    gcce_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .cmd         (cmd),
        .sts         (sts),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

`default_nettype wire
